>>> rtl/core/uhe_pkg.sv
// uhe_pkg: shared types and constants for the url host extractor
// byte codes, status codes, result field widths and the result struct
// no dependencies
package uhe_pkg;

    // width of the offset and length fields of a result
    localparam int OFF_W = 13;
    localparam int STATUS_W = 2;
    localparam int BYTE_W = 8;

    // default longest url that is examined
    localparam int MAX_URL_LEN_DEF = 4096;

    // master-side tdata packing, padded to whole bytes
    localparam int RES_W = STATUS_W + 2 * OFF_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int M_PAD_W = M_TDATA_W - RES_W;

    typedef logic [BYTE_W-1:0] byte_t;

    // delimiter bytes
    localparam byte_t CHAR_COLON = 8'h3a;
    localparam byte_t CHAR_SLASH = 8'h2f;
    localparam byte_t CHAR_QUEST = 8'h3f;
    localparam byte_t CHAR_HASH = 8'h23;
    localparam byte_t CHAR_AT = 8'h40;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK = 2'd0,
        STATUS_NO_SCHEME = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic [OFF_W-1:0] host_offset;
        logic [OFF_W-1:0] host_length;
    } result_t;

    // '/', '?' or '#' ends the authority part
    function automatic logic is_path_mark(input byte_t b);
        return (b == CHAR_SLASH) || (b == CHAR_QUEST) || (b == CHAR_HASH);
    endfunction

endpackage

>>> rtl/core/uhe_scan.sv
// uhe_scan: per-url scan state and the single-pass update for one byte
// finds "://", skips userinfo, tracks host start and end, builds the result
// depends on uhe_pkg
module uhe_scan
    import uhe_pkg::*;
#(
    parameter int MAX_URL_LEN = MAX_URL_LEN_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,       // one byte is consumed this cycle
    input  byte_t   url_byte,
    input  logic    last_byte,
    output result_t res         // result for a step with last_byte set
);

    localparam int PW = $clog2(MAX_URL_LEN + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_URL_LEN);

    logic          sep_reg, sep_next;
    logic [15:0]   recent_reg, recent_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] begin_reg, begin_next;
    logic [PW-1:0] finish_reg, finish_next;
    logic          closed_reg, closed_next;
    logic          open_reg, open_next;
    logic          ovf_reg, ovf_next;

    logic [PW-1:0] pos_inc;
    logic          in_range;
    logic          path_mark;

    assign pos_inc = pos_reg + 1'b1;
    assign in_range = pos_reg < MAX_POS;
    assign path_mark = is_path_mark(url_byte);

    // state after taking the current byte
    always_comb
    begin
        sep_next = sep_reg;
        recent_next = recent_reg;
        pos_next = pos_reg;
        begin_next = begin_reg;
        finish_next = finish_reg;
        closed_next = closed_reg;
        open_next = open_reg;
        ovf_next = ovf_reg;
        if (in_range)
        begin
            pos_next = pos_inc;
            recent_next = {recent_reg[7:0], url_byte};
            priority if (!sep_reg)
            begin
                if (recent_reg == {CHAR_COLON, CHAR_SLASH} && url_byte == CHAR_SLASH)
                begin
                    sep_next = 1'b1;
                    begin_next = pos_inc;
                    finish_next = pos_inc;
                    closed_next = 1'b0;
                    open_next = 1'b1;
                end
            end
            else if (open_reg && url_byte == CHAR_AT)
            begin
                // userinfo ends, host restarts after the '@'
                begin_next = pos_inc;
                finish_next = pos_inc;
                closed_next = 1'b0;
                open_next = 1'b0;
            end
            else
            begin
                if (open_reg && path_mark)
                    open_next = 1'b0;
                if (!closed_reg)
                begin
                    if (url_byte == CHAR_COLON || path_mark)
                        closed_next = 1'b1;
                    else
                        finish_next = pos_inc;
                end
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // result from the updated state
    always_comb
    begin
        res.status = STATUS_OK;
        res.host_offset = '0;
        res.host_length = '0;
        priority if (ovf_next)
            res.status = STATUS_TOO_LONG;
        else if (!sep_next)
            res.status = STATUS_NO_SCHEME;
        else
        begin
            res.host_offset = OFF_W'(begin_next);
            res.host_length = OFF_W'(finish_next - begin_next);
        end
    end

    // state registers, cleared after the final byte of each url
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= 1'b0;
            recent_reg <= '0;
            pos_reg <= '0;
            begin_reg <= '0;
            finish_reg <= '0;
            closed_reg <= 1'b0;
            open_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                sep_reg <= 1'b0;
                recent_reg <= '0;
                pos_reg <= '0;
                begin_reg <= '0;
                finish_reg <= '0;
                closed_reg <= 1'b0;
                open_reg <= 1'b0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                sep_reg <= sep_next;
                recent_reg <= recent_next;
                pos_reg <= pos_next;
                begin_reg <= begin_next;
                finish_reg <= finish_next;
                closed_reg <= closed_next;
                open_reg <= open_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

>>> rtl/core/uhe_out_reg.sv
// uhe_out_reg: result register on the master side of the stream
// holds one result beat until it is taken, packs it into tdata
// depends on uhe_pkg
module uhe_out_reg
    import uhe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,      // only asserted while free is high
    input  result_t              res,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, host_offset, host_length, zero pad
);

    logic    valid_reg;
    result_t res_reg;

    assign free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata = {{M_PAD_W{1'b0}}, res_reg.host_length, res_reg.host_offset,
                      res_reg.status};

    // beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

>>> rtl/core/url_host_extractor.sv
// url_host_extractor: top level; input register, byte scan, result register
// a final byte passes the input register, then the result register, before m_tvalid rises
// throughput: one byte per cycle; s_tready drops only while a final byte waits
// for a stalled result register. reset: asynchronous, active low, clears all
// scan state and both valid flags. depends on uhe_pkg, uhe_scan, uhe_out_reg
module url_host_extractor
    import uhe_pkg::*;
#(
    parameter int MAX_URL_LEN = MAX_URL_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // url_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, host_offset, host_length, zero pad
);

    logic    in_valid_reg;
    byte_t   in_byte_reg;
    logic    in_last_reg;
    logic    in_move;
    logic    out_free;
    logic    step;
    result_t res;

    // the held byte moves on unless it is a final byte facing a full result slot
    assign in_move = !in_valid_reg || !in_last_reg || out_free;
    assign s_tready = in_move;
    assign step = in_valid_reg && in_move;

    // input beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_move)
            in_valid_reg <= s_tvalid;
    end

    // input beat payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_move)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    uhe_scan #(
        .MAX_URL_LEN(MAX_URL_LEN)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .url_byte (in_byte_reg),
        .last_byte(in_last_reg),
        .res      (res)
    );

    uhe_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step && in_last_reg),
        .res     (res),
        .free    (out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

>>> rtl/core/uhe_checker.sv
// uhe_checker: port-level checks on the url host extractor, bound to the top
// covers result beat hold, field rules, latency and input stall cause
// depends on uhe_pkg
module uhe_checker
    import uhe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 s_tlast,   // last_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata    // status, host_offset, host_length, zero pad
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    // failed status carries zero fields, padding is always zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:RES_W] == '0) &&
            ((m_tdata[STATUS_W-1:0] == STATUS_OK) ||
             (m_tdata[RES_W-1:STATUS_W] == '0)))
    else $error("bad result fields");

    // a fresh result follows an accepted final input byte through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a final byte");

    // input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

endmodule

bind url_host_extractor uhe_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> bench/url_host_extractor_tb.sv
// url_host_extractor_tb: self-checking bench for the url host extractor
// drives url bytes on the slave stream and checks each status/offset/length beat
// depends on uhe_pkg and url_host_extractor
`timescale 1ns / 100ps

module url_host_extractor_tb;
    import uhe_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1800;
    localparam int MAX_GAP = 13;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {URL_WELL_FORMED, URL_BROKEN_SEP, URL_NOISE} url_kind_t;

    // tracks the scan state of the current url and the host results still owed
    class host_scoreboard;
        bit sep_seen;
        logic [15:0] prev_two;
        int unsigned pos;
        int unsigned host_first;
        int unsigned host_stop;
        bit host_done;
        bit userinfo_open;
        bit overflow;
        result_t host_q[$];
        int errors;

        function bit ends_authority(byte_t b);
            return (b == CHAR_SLASH) || (b == CHAR_QUEST) || (b == CHAR_HASH);
        endfunction

        // one accepted url byte; queues a result on the final byte
        function void note_byte(byte_t b, bit is_last);
            result_t res;
            logic [31:0] span;
            if (pos < MAX_URL_LEN_DEF) begin
                if (!sep_seen) begin
                    // third byte of "://" opens the host
                    if (prev_two == {CHAR_COLON, CHAR_SLASH} && b == CHAR_SLASH) begin
                        sep_seen = 1'b1;
                        host_first = pos + 1;
                        host_stop = pos + 1;
                        host_done = 1'b0;
                        userinfo_open = 1'b1;
                    end
                end else if (userinfo_open && b == CHAR_AT) begin
                    // first at sign skips the userinfo
                    host_first = pos + 1;
                    host_stop = pos + 1;
                    host_done = 1'b0;
                    userinfo_open = 1'b0;
                end else begin
                    if (userinfo_open && ends_authority(b))
                        userinfo_open = 1'b0;
                    if (!host_done) begin
                        if (b == CHAR_COLON || ends_authority(b))
                            host_done = 1'b1;
                        else
                            host_stop = pos + 1;
                    end
                end
                prev_two = {prev_two[7:0], b};
                pos++;
            end else begin
                overflow = 1'b1;
            end

            if (is_last) begin
                res.host_offset = '0;
                res.host_length = '0;
                if (overflow) begin
                    res.status = STATUS_TOO_LONG;
                end else if (!sep_seen) begin
                    res.status = STATUS_NO_SCHEME;
                end else begin
                    span = host_stop - host_first;
                    res.status = STATUS_OK;
                    res.host_offset = host_first[OFF_W-1:0];
                    res.host_length = span[OFF_W-1:0];
                end
                host_q.push_back(res);
                sep_seen = 1'b0;
                prev_two = '0;
                pos = 0;
                host_first = 0;
                host_stop = 0;
                host_done = 1'b0;
                userinfo_open = 1'b0;
                overflow = 1'b0;
            end
        endfunction

        // one accepted result beat against the oldest owed result
        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t want;
            logic [STATUS_W-1:0] got_status;
            logic [OFF_W-1:0] got_offset;
            logic [OFF_W-1:0] got_length;
            got_status = data[STATUS_W-1:0];
            got_offset = data[STATUS_W +: OFF_W];
            got_length = data[STATUS_W+OFF_W +: OFF_W];
            if (host_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, status %0d offset %0d length %0d",
                         $time, got_status, got_offset, got_length);
            end else begin
                want = host_q.pop_front();
                if (got_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got_status);
                end
                if (got_offset !== want.host_offset) begin
                    errors++;
                    $display("%0t: host_offset expected %0d actual %0d",
                             $time, want.host_offset, got_offset);
                end
                if (got_length !== want.host_length) begin
                    errors++;
                    $display("%0t: host_length expected %0d actual %0d",
                             $time, want.host_length, got_length);
                end
            end
        endfunction

        function int pending();
            return host_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;    // url_byte
    logic s_tlast = 1'b0;               // last_byte
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;      // status, host_offset, host_length, zero pad

    host_scoreboard sb = new;
    byte_t url_buf[$];
    int random_bytes = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    url_host_extractor #(
        .MAX_URL_LEN(MAX_URL_LEN_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic byte_t letter();
        return byte_t'("a" + $urandom_range(0, 25));
    endfunction

    function automatic byte_t host_char();
        case ($urandom_range(0, 15))
            0: return ".";
            1: return "-";
            2: return CHAR_AT;
            3: return byte_t'($urandom_range(0, 255));
            4, 5: return byte_t'("0" + $urandom_range(0, 9));
            default: return letter();
        endcase
    endfunction

    function automatic byte_t path_mark();
        case ($urandom_range(0, 2))
            0: return CHAR_SLASH;
            1: return CHAR_QUEST;
            default: return CHAR_HASH;
        endcase
    endfunction

    function automatic byte_t path_char();
        case ($urandom_range(0, 9))
            0, 1: return path_mark();
            2: return CHAR_AT;
            3: return CHAR_COLON;
            4: return byte_t'($urandom_range(0, 255));
            default: return host_char();
        endcase
    endfunction

    // send the buffered url beat by beat, tlast on the final byte
    task automatic send_url(bit quiet);
        int gap;
        bit is_last;
        for (int i = 0; i < url_buf.size(); i++) begin
            gap = pick_gap(quiet);
            is_last = (i == url_buf.size() - 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= url_buf[i];
            s_tlast <= is_last;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            sb.note_byte(url_buf[i], is_last);
        end
        url_buf.delete();
    endtask

    task automatic send_text(string s);
        foreach (s[i]) url_buf.push_back(s[i]);
        send_url(1'b0);
    endtask

    // mostly well formed urls with random parts, some broken separators and noise
    task automatic build_random_url();
        url_kind_t kind;
        int r;
        r = $urandom_range(0, 19);
        kind = (r < 14) ? URL_WELL_FORMED : (r < 17) ? URL_BROKEN_SEP : URL_NOISE;
        if (kind == URL_NOISE) begin
            repeat ($urandom_range(1, 16))
                url_buf.push_back(($urandom_range(0, 3) == 0) ? path_char()
                                                              : byte_t'($urandom_range(0, 255)));
        end else begin
            // scheme
            repeat ($urandom_range(0, 5)) url_buf.push_back(letter());
            if (kind == URL_WELL_FORMED) begin
                url_buf.push_back(CHAR_COLON);
                url_buf.push_back(CHAR_SLASH);
                url_buf.push_back(CHAR_SLASH);
            end else begin
                repeat ($urandom_range(1, 3))
                    url_buf.push_back($urandom_range(0, 1) ? CHAR_COLON : CHAR_SLASH);
            end
            // userinfo
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(0, 6))
                    url_buf.push_back(($urandom_range(0, 4) == 0) ? CHAR_COLON : host_char());
                url_buf.push_back(CHAR_AT);
            end
            // host
            repeat ($urandom_range(0, 10)) url_buf.push_back(host_char());
            // port
            if ($urandom_range(0, 2) == 0) begin
                url_buf.push_back(CHAR_COLON);
                repeat ($urandom_range(0, 5)) url_buf.push_back(byte_t'("0" + $urandom_range(0, 9)));
            end
            // path, query or fragment, sometimes with a second separator
            if ($urandom_range(0, 1) == 0) begin
                url_buf.push_back(path_mark());
                repeat ($urandom_range(0, 10)) url_buf.push_back(path_char());
                if ($urandom_range(0, 7) == 0) begin
                    url_buf.push_back(CHAR_COLON);
                    url_buf.push_back(CHAR_SLASH);
                    url_buf.push_back(CHAR_SLASH);
                end
            end
        end
    endtask

    // stimulus
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: port delimiter, separator at the end, no separator,
        // userinfo with a later at sign, byte extremes
        send_text("a://h:#");
        send_text("x://");
        send_text("ab");
        send_text("://u@v@w?");
        url_buf.push_back(8'h00);
        send_url(1'b0);
        url_buf.push_back(8'hff);
        send_url(1'b0);

        // random urls; the result side holds off once halfway through
        while (random_bytes < RANDOM_BYTES) begin
            build_random_url();
            random_bytes += url_buf.size();
            if (!hold_done && random_bytes > RANDOM_BYTES / 2) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            send_url($urandom_range(0, 3) == 0);
        end
        s_tvalid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin : result_sink
        int gap;
        bit quiet;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 7) == 0)
                quiet = !quiet;
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = pick_gap(quiet);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
